FILE: sv/lfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Logistic evaluator package
// Shared constants, command codes and the side-band struct of the pipeline.
// ----------------------------------------------------------------------------
package lfe_pkg;

  localparam int WORK_BITS    = 62;
  localparam logic [63:0] ONE_W = 64'h4000_0000_0000_0000;
  localparam int TAYLOR_TERMS = 20;
  localparam int SQUARINGS    = 6;
  localparam int RECIP_STEPS  = 63;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  localparam logic REG_LOCATION    = 1'b0;
  localparam logic REG_SCALE_RECIP = 1'b1;

  typedef enum logic [1:0] {
    CMD_CDF  = 2'd0,
    CMD_PDF  = 2'd1,
    CMD_DPDF = 2'd2
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] cmd;
    logic       zneg;
  } side_t;

endpackage

FILE: sv/lfe_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay line
// Fixed-depth shift register that keeps values aligned across pipeline stages.
// ----------------------------------------------------------------------------
module lfe_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) sr_r[i] <= '0;
    end else begin
      sr_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q_o = sr_r[DEPTH-1];

endmodule

FILE: sv/lfe_mulshr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined 64x64 multiply and shift
// Four registered 32x32 partial products, then sum, optional half-up round
// and right shift into a registered output.
// ----------------------------------------------------------------------------
module lfe_mulshr #(
  parameter int SHIFT = 62,
  parameter bit ROUND = 1'b1
) (
  input  logic        clk,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [128:0] sum;
  logic [128:0] rnd;
  logic [63:0]  p_r;

  always_ff @(posedge clk) begin
    p00_r <= 64'(a_i[31:0])  * 64'(b_i[31:0]);
    p01_r <= 64'(a_i[31:0])  * 64'(b_i[63:32]);
    p10_r <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
    p11_r <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
  end

  always_comb begin
    rnd = ROUND ? (129'(1) << (SHIFT - 1)) : '0;
    sum = 129'(p00_r) + (129'(p01_r) << 32) + (129'(p10_r) << 32) + (129'(p11_r) << 64)
          + rnd;
  end

  always_ff @(posedge clk) begin
    p_r <= 64'(sum >> SHIFT);
  end

  assign p_o = p_r;

endmodule

FILE: sv/lfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Take a command, subtract the location, scale by the reciprocal and clamp.
// ----------------------------------------------------------------------------
module lfe_front #(
  parameter int FRACTION_BITS = 16,
  parameter int AW            = FRACTION_BITS + 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_cmd,
  input  logic [31:0]   in_point,
  input  logic [31:0]   loc,
  input  logic [31:0]   recip,
  input  logic          q_full,
  output logic          push_valid,
  output logic [AW+2:0] push_data
);

  localparam logic [64:0] ZLIM = 65'(32) << FRACTION_BITS;
  localparam logic [64:0] HALF = 65'(1) << (FRACTION_BITS - 1);

  logic        v1_r, v2_r;
  logic [1:0]  cmd1_r, cmd2_r;
  logic        zneg1_r, zneg2_r;
  logic [32:0] mag1_r;
  logic [AW-1:0] a2_r;

  logic        stall;
  logic [32:0] diff;
  logic [63:0] prod;
  logic [64:0] scaled;
  logic [64:0] clamped;

  assign stall = v2_r && q_full;
  assign busy  = stall;

  always_comb begin
    diff    = 33'(signed'(in_point)) - 33'(signed'(loc));
    prod    = 64'(mag1_r[31:0]) * 64'(recip);
    if (mag1_r[32]) prod = prod + {recip, 32'b0};
    scaled  = (65'(prod) + HALF) >> FRACTION_BITS;
    clamped = (scaled > ZLIM) ? ZLIM : scaled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (!stall) begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  // Payload: advance whenever the queue can take the stage two item.
  always_ff @(posedge clk) begin
    if (!stall) begin
      cmd1_r  <= in_cmd;
      zneg1_r <= diff[32];
      mag1_r  <= diff[32] ? 33'(-diff) : diff;
      cmd2_r  <= cmd1_r;
      zneg2_r <= zneg1_r && (clamped != '0);
      a2_r    <= AW'(clamped);
    end
  end

  assign push_valid = v2_r && !q_full;
  assign push_data  = {cmd2_r, zneg2_r, a2_r};

endmodule

FILE: sv/lfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoupling queue
// Small register FIFO between front and back; drains whenever it holds data.
// ----------------------------------------------------------------------------
module lfe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push_valid) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_valid) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop_valid)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + CW'(push_valid) - CW'(pop_valid);
    end
  end

endmodule

FILE: sv/lfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Exponential, reciprocal and the cdf / pdf / derivative products, pipelined
// so that one item enters every cycle.
// ----------------------------------------------------------------------------
module lfe_back #(
  parameter int FRACTION_BITS = 16,
  parameter int AW            = FRACTION_BITS + 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [AW+2:0] in_data,
  input  logic [31:0]   recip,
  output logic          out_valid,
  output logic [31:0]   out_value,
  output logic          out_saturated
);

  localparam int SW = $bits(lfe_pkg::side_t);
  localparam int NT = lfe_pkg::TAYLOR_TERMS;
  localparam int NS = lfe_pkg::SQUARINGS;
  localparam int NR = lfe_pkg::RECIP_STEPS;
  localparam logic [63:0] CDF_HALF = 64'(1) << (61 - FRACTION_BITS);

  logic [63:0] r64;
  assign r64 = {32'b0, recip};

  // Horner evaluation of e^-(a/64)
  logic [63:0]          acc_s  [NT+1];
  logic [63:0]          y_s    [NT+1];
  lfe_pkg::side_t       side_h [NT+1];

  assign acc_s[0]         = lfe_pkg::ONE_W;
  assign y_s[0]           = 64'(in_data[AW-1:0]) << (56 - FRACTION_BITS);
  assign side_h[0].valid  = in_valid;
  assign side_h[0].cmd    = in_data[AW+2:AW+1];
  assign side_h[0].zneg   = in_data[AW];

  for (genvar j = 0; j < NT; j++) begin : g_horner
    localparam int K = NT - j;
    localparam logic [64:0] ALL1  = {1'b0, {64{1'b1}}};
    localparam logic [63:0] MAGIC = 64'(ALL1 / 65'(K));

    logic [63:0] prod, qq, prod_d;
    logic [63:0] rem_r, qq_r, acc_r;
    logic [63:0] quot;

    lfe_mulshr #(.SHIFT(lfe_pkg::WORK_BITS), .ROUND(1'b1)) u_mul (
      .clk(clk), .a_i(y_s[j]), .b_i(acc_s[j]), .p_o(prod)
    );
    lfe_mulshr #(.SHIFT(64), .ROUND(1'b0)) u_div (
      .clk(clk), .a_i(prod), .b_i(MAGIC), .p_o(qq)
    );
    lfe_delay #(.WIDTH(64), .DEPTH(2)) u_pd (
      .clk(clk), .rst_n(rst_n), .d_i(prod), .q_o(prod_d)
    );

    // Correct the quotient estimate, then form 1 - q.
    always_comb begin
      quot = qq_r;
      if (rem_r >= 64'(2 * K))  quot = qq_r + 64'd2;
      else if (rem_r >= 64'(K)) quot = qq_r + 64'd1;
    end

    always_ff @(posedge clk) begin
      rem_r <= prod_d - 64'(qq * 64'(K));
      qq_r  <= qq;
      acc_r <= lfe_pkg::ONE_W - quot;
    end
    assign acc_s[j+1] = acc_r;

    lfe_delay #(.WIDTH(64), .DEPTH(6)) u_yd (
      .clk(clk), .rst_n(rst_n), .d_i(y_s[j]), .q_o(y_s[j+1])
    );
    lfe_delay #(.WIDTH(SW), .DEPTH(6)) u_sd (
      .clk(clk), .rst_n(rst_n), .d_i(side_h[j]), .q_o(side_h[j+1])
    );
  end

  // Raise to the 64th power
  logic [63:0]    sq_s   [NS+1];
  lfe_pkg::side_t side_q [NS+1];
  assign sq_s[0]   = acc_s[NT];
  assign side_q[0] = side_h[NT];

  for (genvar i = 0; i < NS; i++) begin : g_square
    lfe_mulshr #(.SHIFT(lfe_pkg::WORK_BITS), .ROUND(1'b1)) u_sq (
      .clk(clk), .a_i(sq_s[i]), .b_i(sq_s[i]), .p_o(sq_s[i+1])
    );
    lfe_delay #(.WIDTH(SW), .DEPTH(2)) u_sd (
      .clk(clk), .rst_n(rst_n), .d_i(side_q[i]), .q_o(side_q[i+1])
    );
  end

  // Restoring division u = 1 / (1 + t), one quotient bit per stage
  logic [63:0]    rem_s  [NR+1];
  logic [63:0]    q_s    [NR+1];
  logic [63:0]    d_s    [NR+1];
  logic [63:0]    t_s    [NR+1];
  lfe_pkg::side_t side_r [NR+1];

  assign rem_s[0]  = lfe_pkg::ONE_W;
  assign q_s[0]    = '0;
  assign d_s[0]    = lfe_pkg::ONE_W + sq_s[NS];
  assign t_s[0]    = sq_s[NS];
  assign side_r[0] = side_q[NS];

  for (genvar i = 0; i < NR; i++) begin : g_recip
    logic        ge;
    logic [63:0] rem_r, q_r, d_r, t_r;
    lfe_pkg::side_t side_rr;

    assign ge = (rem_s[i] >= d_s[i]);

    always_ff @(posedge clk) begin
      rem_r <= (ge ? rem_s[i] - d_s[i] : rem_s[i]) << 1;
      q_r   <= {q_s[i][62:0], ge};
      d_r   <= d_s[i];
      t_r   <= t_s[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) side_rr <= '0;
      else        side_rr <= side_r[i];
    end

    assign rem_s[i+1]  = rem_r;
    assign q_s[i+1]    = q_r;
    assign d_s[i+1]    = d_r;
    assign t_s[i+1]    = t_r;
    assign side_r[i+1] = side_rr;
  end

  // Products: s = t*u, p = s*u, then the three function values
  logic [63:0] t0, u0, s2, t2, u2, p4, s4, t4, u4;
  logic [63:0] pdf6, e6, u6, dd8, m10, res12;
  logic [31:0] cdf4, cdf12, pdf12;
  lfe_pkg::side_t sd2, sd4, sd12;

  assign t0 = t_s[NR];
  assign u0 = q_s[NR];

  lfe_mulshr #(.SHIFT(lfe_pkg::WORK_BITS), .ROUND(1'b1)) u_s (
    .clk(clk), .a_i(t0), .b_i(u0), .p_o(s2)
  );
  lfe_delay #(.WIDTH(128), .DEPTH(2)) u_tu2 (
    .clk(clk), .rst_n(rst_n), .d_i({t0, u0}), .q_o({t2, u2})
  );
  lfe_delay #(.WIDTH(SW), .DEPTH(2)) u_sd2 (
    .clk(clk), .rst_n(rst_n), .d_i(side_r[NR]), .q_o(sd2)
  );

  lfe_mulshr #(.SHIFT(lfe_pkg::WORK_BITS), .ROUND(1'b1)) u_p (
    .clk(clk), .a_i(s2), .b_i(u2), .p_o(p4)
  );
  lfe_delay #(.WIDTH(192), .DEPTH(2)) u_stu4 (
    .clk(clk), .rst_n(rst_n), .d_i({s2, t2, u2}), .q_o({s4, t4, u4})
  );
  lfe_delay #(.WIDTH(SW), .DEPTH(2)) u_sd4 (
    .clk(clk), .rst_n(rst_n), .d_i(sd2), .q_o(sd4)
  );

  assign cdf4 = 32'(((sd4.zneg ? s4 : u4) + CDF_HALF) >> (lfe_pkg::WORK_BITS - FRACTION_BITS));

  lfe_mulshr #(.SHIFT(lfe_pkg::WORK_BITS), .ROUND(1'b1)) u_pdf (
    .clk(clk), .a_i(r64), .b_i(p4), .p_o(pdf6)
  );
  lfe_mulshr #(.SHIFT(lfe_pkg::WORK_BITS), .ROUND(1'b1)) u_e (
    .clk(clk), .a_i(p4), .b_i(lfe_pkg::ONE_W - t4), .p_o(e6)
  );
  lfe_delay #(.WIDTH(64), .DEPTH(2)) u_u6 (
    .clk(clk), .rst_n(rst_n), .d_i(u4), .q_o(u6)
  );
  lfe_mulshr #(.SHIFT(lfe_pkg::WORK_BITS), .ROUND(1'b1)) u_dd (
    .clk(clk), .a_i(e6), .b_i(u6), .p_o(dd8)
  );
  lfe_mulshr #(.SHIFT(30), .ROUND(1'b1)) u_m (
    .clk(clk), .a_i(r64), .b_i(dd8), .p_o(m10)
  );
  lfe_mulshr #(.SHIFT(FRACTION_BITS + 32), .ROUND(1'b1)) u_res (
    .clk(clk), .a_i(r64), .b_i(m10), .p_o(res12)
  );

  lfe_delay #(.WIDTH(32 + SW), .DEPTH(8)) u_cd12 (
    .clk(clk), .rst_n(rst_n), .d_i({cdf4, sd4}), .q_o({cdf12, sd12})
  );
  lfe_delay #(.WIDTH(32), .DEPTH(6)) u_pd12 (
    .clk(clk), .rst_n(rst_n), .d_i(pdf6[31:0]), .q_o(pdf12)
  );

  // Select, saturate and register the result
  logic [31:0] val;
  logic        sat;

  always_comb begin
    val = '0;
    sat = 1'b0;
    case (sd12.cmd)
      lfe_pkg::CMD_CDF: val = cdf12;
      lfe_pkg::CMD_PDF: val = pdf12;
      lfe_pkg::CMD_DPDF: begin
        if (sd12.zneg) begin
          if (res12 > 64'(lfe_pkg::POS_MAX)) begin
            val = lfe_pkg::POS_MAX;
            sat = 1'b1;
          end else begin
            val = res12[31:0];
          end
        end else begin
          if (res12 > 64'(lfe_pkg::NEG_MAX)) begin
            val = lfe_pkg::NEG_MAX;
            sat = 1'b1;
          end else begin
            val = -res12[31:0];
          end
        end
      end
      default: begin
        val = '0;
        sat = 1'b0;
      end
    endcase
  end

  logic        ov_r, os_r;
  logic [31:0] oval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      os_r <= 1'b0;
    end else begin
      ov_r <= sd12.valid;
      os_r <= sd12.valid && sat;
    end
  end

  always_ff @(posedge clk) begin
    oval_r <= val;
  end

  assign out_valid     = ov_r;
  assign out_value     = oval_r;
  assign out_saturated = os_r;

endmodule

FILE: sv/logistic_pdf_cdf_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Logistic distribution evaluator
// Computes the cdf, pdf or pdf derivative of a logistic distribution in
// signed fixed point, one command per cycle while busy is low.
// ----------------------------------------------------------------------------
// A command (in_cmd, in_point) is taken on any cycle where start is high and
// busy is low; a new command may follow in every cycle. Each command returns
// exactly one result, in order, after passing the 2 front stages, the queue,
// 20 Horner steps for the exponential, 6 squarings, a 63-stage restoring
// divider for 1/(1+t), the product stages and the output register. The
// result shows on out_value / out_saturated for one cycle while out_valid
// is high; it cannot be held off, so capture it on that cycle.
// Configuration (index 0 location, index 1 reciprocal scale) is written
// through cfg_valid/cfg_ready; the user must write it only while no command
// is in flight, as the block does not enforce this; cfg_ready is always high.
// ----------------------------------------------------------------------------
module logistic_pdf_cdf_unit_top #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_point,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = FRACTION_BITS + 6;

  logic [31:0] loc_r, recip_r;

  // Configuration registers: transfer on valid and ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r   <= '0;
      recip_r <= 32'(1) << FRACTION_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lfe_pkg::REG_LOCATION:    loc_r   <= cfg_data;
        lfe_pkg::REG_SCALE_RECIP: recip_r <= cfg_data;
        default: begin
          loc_r <= loc_r;
        end
      endcase
    end
  end

  // Front: standardize and clamp the point.
  logic          q_full, push_valid, pop_valid;
  logic [AW+2:0] push_data, pop_data;

  lfe_front #(.FRACTION_BITS(FRACTION_BITS), .AW(AW)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_point(in_point), .loc(loc_r), .recip(recip_r),
    .q_full(q_full), .push_valid(push_valid), .push_data(push_data)
  );

  // Queue: decouple front from back.
  lfe_queue #(.WIDTH(AW + 3), .DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n), .push_valid(push_valid), .push_data(push_data),
    .full(q_full), .pop_valid(pop_valid), .pop_data(pop_data)
  );

  // Back: exponential, reciprocal and the selected function.
  lfe_back #(.FRACTION_BITS(FRACTION_BITS), .AW(AW)) u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(pop_valid), .in_data(pop_data),
    .recip(recip_r), .out_valid(out_valid), .out_value(out_value),
    .out_saturated(out_saturated)
  );

  // The back end drains the queue every cycle, so it never fills.
  a_queue_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    !q_full) else $error("decoupling queue filled up");

  a_sat_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_saturated |-> out_valid) else $error("saturation flag without result");

  a_sat_value_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_saturated |-> (out_value == lfe_pkg::POS_MAX || out_value == lfe_pkg::NEG_MAX))
    else $error("saturated result not at a limit");

  a_no_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !busy) else $error("busy right after reset");

endmodule

FILE: dv/logistic_pdf_cdf_unit_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Logistic evaluator testbench
// Drives cdf, pdf, pdf-derivative and reserved commands into the evaluator
// through directed rows and random phases, rewrites location and reciprocal
// scale between phases, and checks every result against a typed row value or
// a bit-exact fixed-point model of the exponential, divider and product chain.
// ----------------------------------------------------------------------------
module logistic_pdf_cdf_unit_top_tb;

  localparam int          FB          = 16;
  localparam logic [1:0]  CMD_UNKNOWN = 2'd3;   // reserved code, yields all zeros
  localparam int          DRAIN       = 260;    // covers the whole pipeline
  localparam int          STALL_LIMIT = 20000;  // cycles without any transfer
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_ITEMS = 119;
  localparam logic [63:0] Z_CLAMP     = 64'd32 << FB;

  // Row of the directed table: either a register write or one command.
  typedef struct {
    bit          is_cfg;
    logic        idx;
    logic [1:0]  cmd;
    logic [31:0] data;     // register data or evaluation point
    bit          typed;    // expected result written into the row
    logic [31:0] ev;
    logic        es;
  } row_t;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = lfe_pkg::CMD_CDF;
  logic [31:0] in_point = '0;
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = lfe_pkg::REG_LOCATION;
  logic [31:0] cfg_data = '0;

  // Model copy of the two registers.
  logic [31:0] model_location = '0;
  logic [31:0] model_recip    = 32'h0001_0000;

  result_t pending_results[$];
  int      failures = 0;
  int      quiet_cycles = 0;
  int      burst_left = 0;

  logistic_pdf_cdf_unit_top #(.FRACTION_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_point(in_point),
    .out_valid(out_valid), .out_value(out_value), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Fixed-point model
  // --------------------------------------------------------------------------

  // Product a*b shifted right by s, rounded half up, kept to 64 bits.
  function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
    logic [127:0] p;
    p = a * b;
    p = p + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  // e^-a for a in Q.FB, returned in Q2.62: Horner series on a/64, then squared SQUARINGS times.
  function automatic logic [63:0] exp_neg_q62(input logic [63:0] a);
    logic [63:0] y;
    logic [63:0] acc;
    y = a << (56 - FB);
    acc = lfe_pkg::ONE_W;
    for (int k = lfe_pkg::TAYLOR_TERMS; k >= 1; k--)
      acc = lfe_pkg::ONE_W - mul_round(y, acc, lfe_pkg::WORK_BITS) / k;
    for (int i = 0; i < lfe_pkg::SQUARINGS; i++)
      acc = mul_round(acc, acc, lfe_pkg::WORK_BITS);
    return acc;
  endfunction

  // Truncating long division 2^124 / d.
  function automatic logic [63:0] recip_q62(input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    rem = lfe_pkg::ONE_W;
    q = '0;
    for (int i = 0; i < lfe_pkg::RECIP_STEPS; i++) begin
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
      rem = rem << 1;
    end
    return q;
  endfunction

  function automatic result_t logistic_eval(input logic [1:0] cmd, input logic [31:0] point);
    result_t     res;
    longint      diff;
    bit          zneg;
    logic [63:0] mag, r, a, t, u, s, p, c, dd, m, mag_res;
    diff = longint'($signed(point)) - longint'($signed(model_location));
    zneg = diff < 0;
    mag = zneg ? 64'(-diff) : 64'(diff);
    r = {32'd0, model_recip};
    a = (mag * r + (64'd1 << (FB - 1))) >> FB;
    if (a > Z_CLAMP)
      a = Z_CLAMP;
    if (a == 0)
      zneg = 1'b0;
    t = exp_neg_q62(a);
    u = recip_q62(lfe_pkg::ONE_W + t);
    s = mul_round(t, u, lfe_pkg::WORK_BITS);
    p = mul_round(s, u, lfe_pkg::WORK_BITS);
    res.value = '0;
    res.sat = 1'b0;
    case (cmd)
      lfe_pkg::CMD_CDF: begin
        c = zneg ? s : u;
        c = (c + (64'd1 << (61 - FB))) >> (lfe_pkg::WORK_BITS - FB);
        res.value = c[31:0];
      end
      lfe_pkg::CMD_PDF: begin
        c = mul_round(r, p, lfe_pkg::WORK_BITS);
        res.value = c[31:0];
      end
      lfe_pkg::CMD_DPDF: begin
        dd = mul_round(mul_round(p, lfe_pkg::ONE_W - t, lfe_pkg::WORK_BITS), u,
                       lfe_pkg::WORK_BITS);
        m = mul_round(r, dd, 30);
        mag_res = mul_round(r, m, FB + 32);
        if (zneg) begin
          if (mag_res > {32'd0, lfe_pkg::POS_MAX}) begin
            mag_res = {32'd0, lfe_pkg::POS_MAX};
            res.sat = 1'b1;
          end
          res.value = mag_res[31:0];
        end else begin
          if (mag_res > {32'd0, lfe_pkg::NEG_MAX}) begin
            mag_res = {32'd0, lfe_pkg::NEG_MAX};
            res.sat = 1'b1;
          end
          res.value = 32'(-mag_res);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker and stall watchdog, both on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("logistic_pdf_cdf_unit_top verification failed");
        $finish;
      end
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing pending: value %h sat %b",
                   $time, out_value, out_saturated);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (out_value !== want.value) begin
            $display("%0t: value expected %h actual %h", $time, want.value, out_value);
            failures++;
          end
          if (out_saturated !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, out_saturated);
            failures++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks; all start and end at a falling edge
  // --------------------------------------------------------------------------

  // Send one command in the current burst; open a new burst after a gap.
  task automatic send_command(input logic [1:0] cmd, input logic [31:0] point,
                              input bit typed, input logic [31:0] ev, input logic es);
    result_t want;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 10);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_point <= point;
    do @(posedge clk); while (busy);
    // Transfer done at this edge: record what must come back.
    if (typed) begin
      want.value = ev;
      want.sat = es;
    end else begin
      want = logistic_eval(cmd, point);
    end
    pending_results.push_back(want);
    burst_left--;
    @(negedge clk);
  endtask

  // Hold the sender until every result is back and the pipeline is empty.
  task automatic drain_pipeline();
    start <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lfe_pkg::REG_LOCATION)
      model_location = data;
    else
      model_recip = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random point: mostly close to the location so z lands in the live range.
  function automatic logic [31:0] random_point();
    int spread;
    if ($urandom_range(0, 2) == 0)
      return $urandom();
    spread = $urandom_range(4, 24);
    return model_location + 32'($signed($urandom_range(0, (1 << spread) - 1))
                                - (1 << (spread - 1)));
  endfunction

  function automatic logic [31:0] random_recip();
    case ($urandom_range(0, 7))
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      3:       return $urandom_range(1, 32'h0000_FFFF);
      default: return $urandom_range(32'h0000_4000, 32'h0010_0000);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  row_t directed[] = '{
    // reset setting: location 0, reciprocal scale 1.0
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_CDF,  32'h0000_0000, 1, 32'h0000_8000, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_PDF,  32'h0000_0000, 1, 32'h0000_4000, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_DPDF, 32'h0000_0000, 1, 32'h0000_0000, 0},
    '{0, lfe_pkg::REG_LOCATION, CMD_UNKNOWN,       32'h1234_5678, 1, 32'h0000_0000, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_CDF,  32'h7FFF_FFFF, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_CDF,  32'h8000_0000, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_PDF,  32'h7FFF_FFFF, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_DPDF, 32'h8000_0000, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_DPDF, 32'h0001_8000, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_CDF,  32'hFFFF_FFFF, 0, '0, 0},
    // extreme locations: the largest possible distance
    '{1, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_CDF,  32'h8000_0000, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_CDF,  32'h7FFF_FFFF, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_DPDF, 32'h8000_0000, 1, 32'h0000_0000, 0},
    '{1, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_CDF,  32'h7FFF_FFFF, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_PDF,  32'h8000_0000, 0, '0, 0},
    // zero reciprocal scale: z collapses to 0
    '{1, lfe_pkg::REG_SCALE_RECIP, lfe_pkg::CMD_CDF, 32'h0000_0000, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_CDF,  32'h0000_5555, 1, 32'h0000_8000, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_PDF,  32'h8000_0000, 1, 32'h0000_0000, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_DPDF, 32'h0000_5555, 1, 32'h0000_0000, 0},
    // largest reciprocal scale: the derivative clips on both sides
    '{1, lfe_pkg::REG_SCALE_RECIP, lfe_pkg::CMD_CDF, 32'hFFFF_FFFF, 0, '0, 0},
    '{1, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_CDF,  32'h0000_0000, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_DPDF, 32'h0000_0001, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_DPDF, 32'hFFFF_FFFF, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_PDF,  32'h0000_0001, 0, '0, 0},
    // smallest nonzero reciprocal scale
    '{1, lfe_pkg::REG_SCALE_RECIP, lfe_pkg::CMD_CDF, 32'h0000_0001, 0, '0, 0},
    '{0, lfe_pkg::REG_LOCATION, lfe_pkg::CMD_CDF,  32'h7FFF_FFFF, 0, '0, 0}
  };

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table; drain before any register write.
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain_pipeline();
        write_register(directed[i].idx, directed[i].data);
      end else begin
        send_command(directed[i].cmd, directed[i].data, directed[i].typed,
                     directed[i].ev, directed[i].es);
      end
    end

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_pipeline();
      write_register(lfe_pkg::REG_LOCATION, ($urandom_range(0, 3) == 0) ? $urandom()
                     : 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000));
      write_register(lfe_pkg::REG_SCALE_RECIP,
                     (ph == 0) ? 32'h0001_0000 : random_recip());
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_command(($urandom_range(0, 15) == 0) ? CMD_UNKNOWN : 2'($urandom_range(0, 2)),
                     random_point(), 0, '0, 0);
    end

    // Let the last results arrive, then settle.
    drain_pipeline();
    if (failures == 0)
      $display("logistic_pdf_cdf_unit_top verification clean");
    else
      $display("logistic_pdf_cdf_unit_top verification failed");
    $finish;
  end

endmodule

FILE: logistic_pdf_cdf_unit_top.f
sv/lfe_pkg.sv
sv/lfe_delay.sv
sv/lfe_mulshr.sv
sv/lfe_front.sv
sv/lfe_queue.sv
sv/lfe_back.sv
sv/logistic_pdf_cdf_unit_top.sv
dv/logistic_pdf_cdf_unit_top_tb.sv
